### rtl/core/hmc_pkg.sv
// Shared types, codes and constants of the heater mode controller.
package hmc_pkg;

    localparam int TIMER_W = 16;
    localparam int PHASE_W = 4;
    localparam int FAULT_W = 4;

    // Heater modes
    typedef enum logic [2:0] {
        MODE_ON      = 3'd0,
        MODE_OFF     = 3'd1,
        MODE_VENT    = 3'd2,
        MODE_ERROR   = 3'd3,
        MODE_UNKNOWN = 3'd4
    } mode_t;

    // Word kinds on the input stream
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_STATE = 2'd1;
    localparam logic [1:0] CMD_FAULT = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_RECHECK  = 2'd0;
    localparam logic [1:0] REG_BLINK    = 2'd1;
    localparam logic [1:0] REG_COOLDOWN = 2'd2;

    // Register reset values
    localparam logic [TIMER_W-1:0] RECHECK_RESET  = 16'd100;
    localparam logic [TIMER_W-1:0] BLINK_RESET    = 16'd10;
    localparam logic [TIMER_W-1:0] COOLDOWN_RESET = 16'd6000;

    // Blink and fault constants
    localparam logic [PHASE_W-1:0] PHASE_WRAP    = 4'd10;
    localparam logic [PHASE_W-1:0] ON_LED_SPAN   = 4'd5;
    localparam logic [4:0]         VENT_LED_SPAN = 5'd20;
    localparam logic [FAULT_W-1:0] FAULT_LIMIT   = 4'd12;
    localparam logic [FAULT_W-1:0] FAULT_RESET   = 4'd1;

    typedef struct packed {
        logic [TIMER_W-1:0] recheck_ticks;
        logic [TIMER_W-1:0] blink_ticks;
        logic [TIMER_W-1:0] cooldown_ticks;
    } cfg_t;

    typedef struct packed {
        mode_t              mode;
        logic [PHASE_W-1:0] blink_phase;
        logic [TIMER_W-1:0] recheck_elapsed;
        logic [TIMER_W-1:0] blink_elapsed;
        logic [TIMER_W-1:0] cooldown_elapsed;
        logic               cooldown_started;
        logic [FAULT_W-1:0] fault_counter;
        logic               led_on;
        logic               gas_on;
        logic               vent_on;
    } state_t;

endpackage

### rtl/core/hmc_step.sv
// Next-state logic of the heater mode controller for one input word.
module hmc_step (
    input  hmc_pkg::state_t     state_cur,
    input  hmc_pkg::cfg_t       cfg,
    input  logic [1:0]          cmd,
    input  logic signed [15:0]  temperature,
    input  logic signed [15:0]  setpoint,
    input  logic [2:0]          commanded_state,
    output hmc_pkg::state_t     state_nxt,
    output logic                published
);

    localparam logic [hmc_pkg::TIMER_W-1:0] TIMER_MAX = '1;

    logic [hmc_pkg::TIMER_W-1:0] recheck_inc;
    logic [hmc_pkg::TIMER_W-1:0] blink_inc;
    logic [hmc_pkg::TIMER_W-1:0] cooldown_inc;
    logic [hmc_pkg::PHASE_W-1:0] phase_wrapped;
    hmc_pkg::mode_t              req_mode;
    hmc_pkg::state_t             after_check;

    // Saturating timer increments and phase wrap
    assign recheck_inc  = (state_cur.recheck_elapsed == TIMER_MAX) ? TIMER_MAX
                        : state_cur.recheck_elapsed + 1'b1;
    assign blink_inc    = (state_cur.blink_elapsed == TIMER_MAX) ? TIMER_MAX
                        : state_cur.blink_elapsed + 1'b1;
    assign cooldown_inc = (state_cur.cooldown_elapsed == TIMER_MAX) ? TIMER_MAX
                        : state_cur.cooldown_elapsed + 1'b1;

    // Map out-of-range commanded codes to unknown
    assign req_mode = (commanded_state > 3'(hmc_pkg::MODE_UNKNOWN)) ? hmc_pkg::MODE_UNKNOWN
                    : hmc_pkg::mode_t'(commanded_state);

    // Advance timers and run the thermostat re-check
    always_comb begin
        after_check = state_cur;
        after_check.recheck_elapsed = recheck_inc;
        after_check.blink_elapsed   = blink_inc;
        if (state_cur.cooldown_started) begin
            after_check.cooldown_elapsed = cooldown_inc;
        end
        if (recheck_inc >= cfg.recheck_ticks) begin
            if (temperature >= setpoint) begin
                if (state_cur.mode == hmc_pkg::MODE_ON) begin
                    after_check.cooldown_elapsed = '0;
                    after_check.cooldown_started = 1'b1;
                    after_check.mode             = hmc_pkg::MODE_VENT;
                end
            end else begin
                after_check.mode = hmc_pkg::MODE_ON;
            end
            after_check.recheck_elapsed = '0;
        end
    end

    assign phase_wrapped = (after_check.blink_phase == hmc_pkg::PHASE_WRAP - 1'b1) ? '0
                         : after_check.blink_phase + 1'b1;

    // Apply the word: tick with LED update, state command or fault pulse
    always_comb begin
        state_nxt = state_cur;
        published = 1'b0;
        case (cmd)
            hmc_pkg::CMD_TICK: begin
                state_nxt = after_check;
                if (blink_inc >= cfg.blink_ticks) begin
                    published               = 1'b1;
                    state_nxt.blink_elapsed = '0;
                    case (after_check.mode)
                        hmc_pkg::MODE_ON: begin
                            state_nxt.blink_phase = phase_wrapped;
                            state_nxt.led_on      = phase_wrapped < hmc_pkg::ON_LED_SPAN;
                            state_nxt.gas_on      = 1'b1;
                            state_nxt.vent_on     = 1'b1;
                        end
                        hmc_pkg::MODE_OFF: begin
                            state_nxt.blink_phase = (after_check.blink_phase == '0) ? 4'd1 : '0;
                            state_nxt.led_on      = 1'b0;
                            state_nxt.gas_on      = 1'b0;
                            state_nxt.vent_on     = 1'b0;
                        end
                        hmc_pkg::MODE_VENT: begin
                            state_nxt.blink_phase = phase_wrapped;
                            state_nxt.led_on      = {1'b0, phase_wrapped}
                                                    < hmc_pkg::VENT_LED_SPAN;
                            state_nxt.gas_on      = 1'b0;
                            state_nxt.vent_on     = 1'b1;
                            if (after_check.cooldown_started &&
                                after_check.cooldown_elapsed >= cfg.cooldown_ticks) begin
                                state_nxt.mode = hmc_pkg::MODE_OFF;
                            end
                        end
                        default: begin
                            state_nxt.blink_phase = phase_wrapped;
                            state_nxt.led_on      = phase_wrapped == '0;
                            state_nxt.gas_on      = 1'b0;
                            state_nxt.vent_on     = 1'b0;
                        end
                    endcase
                end
            end
            hmc_pkg::CMD_STATE: begin
                if (req_mode != state_cur.mode) begin
                    state_nxt.blink_phase = '0;
                    state_nxt.mode        = req_mode;
                end
                state_nxt.recheck_elapsed = '0;
            end
            hmc_pkg::CMD_FAULT: begin
                if (state_cur.fault_counter != '0 &&
                    state_cur.fault_counter < hmc_pkg::FAULT_LIMIT) begin
                    state_nxt.fault_counter = state_cur.fault_counter + 1'b1;
                end
            end
            default: begin
                state_nxt = state_cur;
            end
        endcase
    end

endmodule

### rtl/core/heater_mode_controller_top.sv
// Heater mode controller: input stream, state registers and result register.
//
// Takes one word per cycle: a tick, a state command or a fault pulse, and
// returns one result word per input word in the cycle after acceptance. All mode,
// timer and pin updates are combinational between the state registers
// and the result register, so throughput is one word per clock for as long as
// the result side keeps taking words; s_tready drops only while the result
// register holds a word that m_tready has not yet taken. Configuration writes
// take effect on the next clock and are meant for idle periods.
module heater_mode_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [1:0] cmd, [17:2] temperature, [33:18] setpoint, [36:34] commanded_state
    input  logic [39:0] s_tdata,
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] led_on, [1] gas_on, [2] vent_on, [5:3] mode_now,
    // [6] status_published, [10:7] fault_count
    output logic [15:0] m_tdata
);

    hmc_pkg::cfg_t   cfg_reg;
    hmc_pkg::state_t state_reg;
    hmc_pkg::state_t state_next;
    logic            published;
    logic            s_accept;
    logic            m_tvalid_reg;
    logic            m_tvalid_next;
    logic [15:0]     m_tdata_reg;
    logic [15:0]     m_tdata_next;

    // Accept when the result register is empty or drains this cycle
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;

    hmc_step u_step (
        .state_cur       (state_reg),
        .cfg             (cfg_reg),
        .cmd             (s_tdata[1:0]),
        .temperature     (s_tdata[17:2]),
        .setpoint        (s_tdata[33:18]),
        .commanded_state (s_tdata[36:34]),
        .state_nxt       (state_next),
        .published       (published)
    );

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.recheck_ticks  <= hmc_pkg::RECHECK_RESET;
            cfg_reg.blink_ticks    <= hmc_pkg::BLINK_RESET;
            cfg_reg.cooldown_ticks <= hmc_pkg::COOLDOWN_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                hmc_pkg::REG_RECHECK:  cfg_reg.recheck_ticks  <= cfg_wdata;
                hmc_pkg::REG_BLINK:    cfg_reg.blink_ticks    <= cfg_wdata;
                hmc_pkg::REG_COOLDOWN: cfg_reg.cooldown_ticks <= cfg_wdata;
                default:               cfg_reg                <= cfg_reg;
            endcase
        end
    end

    // Mode state, advanced on each accepted word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.mode             <= hmc_pkg::MODE_OFF;
            state_reg.blink_phase      <= '0;
            state_reg.recheck_elapsed  <= '0;
            state_reg.blink_elapsed    <= '0;
            state_reg.cooldown_elapsed <= '0;
            state_reg.cooldown_started <= 1'b0;
            state_reg.fault_counter    <= hmc_pkg::FAULT_RESET;
            state_reg.led_on           <= 1'b0;
            state_reg.gas_on           <= 1'b0;
            state_reg.vent_on          <= 1'b0;
        end else if (s_accept) begin
            state_reg <= state_next;
        end
    end

    // Result register: load on accept, drop when taken
    assign m_tvalid_next = s_accept || (m_tvalid_reg && !m_tready);
    assign m_tdata_next  = {5'd0, state_next.fault_counter, published,
                            3'(state_next.mode), state_next.vent_on,
                            state_next.gas_on, state_next.led_on};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    // Fault count stays within its saturating range
    a_fault_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.fault_counter >= hmc_pkg::FAULT_RESET &&
        state_reg.fault_counter <= hmc_pkg::FAULT_LIMIT)
        else $error("fault counter out of range");

    // Blink phase never reaches the wrap value
    a_phase_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg.blink_phase < hmc_pkg::PHASE_WRAP)
        else $error("blink phase out of range");

    // Cooldown count stays cleared until the cooldown has started
    a_cooldown_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        !state_reg.cooldown_started |-> state_reg.cooldown_elapsed == '0)
        else $error("cooldown counting before start");

    // Every accepted word yields a result word on the next cycle
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> m_tvalid && m_tdata[5:3] == 3'($past(state_next.mode)))
        else $error("result word missing after accept");
`endif

endmodule
